### rtl/core/meat_pkg.sv
package meat_pkg;

	// Default sizes of the table.
	localparam int EDGE_SLOTS_DEF  = 1024;
	localparam int FACE_BITS_DEF   = 16;
	localparam int VERTEX_BITS_DEF = 32;

	// Fixed port widths.
	localparam int OP_W     = 2;
	localparam int VERT_W   = 32;
	localparam int FACE_W   = 16;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_BEGIN = 2'd0,
		OP_ADD   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_EMPTY        = 2'd1,
		ST_NON_MANIFOLD = 2'd2,
		ST_OVERFLOW     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_START,
		S_ADD_SCAN,
		S_RD_SCAN,
		S_RD_DONE,
		S_EMIT
	} state_t;

endpackage

### rtl/core/meat_ram.sv
module meat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/core/mesh_edge_adjacency_table.sv
// Begin, unknown ops and refused adds or reads go straight to the result; a read that
// scans walks every stored edge, and an add walks the stored edges up to a match for
// each edge of its triangle. A stalled result holds the block in its result state.
// Throughput: one item at a time, set by the single table read port, which the
// key compare walks one stored edge per cycle for every edge of a triangle.
// Reset clears the counts, face counter, error and read position; the table
// memory is not cleared, since only entries below the edge count are ever read.
module mesh_edge_adjacency_table #(
	parameter int EDGE_SLOTS  = meat_pkg::EDGE_SLOTS_DEF,
	parameter int FACE_BITS   = meat_pkg::FACE_BITS_DEF,
	parameter int VERTEX_BITS = meat_pkg::VERTEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [meat_pkg::OP_W-1:0]     op,
	input  logic [meat_pkg::VERT_W-1:0]   vert_a,
	input  logic [meat_pkg::VERT_W-1:0]   vert_b,
	input  logic [meat_pkg::VERT_W-1:0]   vert_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [meat_pkg::STATUS_W-1:0] status,
	output logic                          edge_valid,
	output logic [meat_pkg::VERT_W-1:0]   vert_low,
	output logic [meat_pkg::VERT_W-1:0]   vert_high,
	output logic [meat_pkg::FACE_W-1:0]   face_one,
	output logic [meat_pkg::FACE_W-1:0]   face_two,
	output logic                          has_second,
	output logic                          opposite,
	output logic [meat_pkg::COUNT_W-1:0]  edges_total,
	output logic [meat_pkg::COUNT_W-1:0]  boundary_total,
	output logic                          no_more
);

	localparam int AW  = $clog2(EDGE_SLOTS);
	localparam int CW  = $clog2(EDGE_SLOTS + 1);
	localparam int VB  = VERTEX_BITS;
	localparam int FB  = FACE_BITS;
	localparam int KW  = 2 * VB;
	localparam int IW  = 2 * FB + 3;
	localparam int WW  = KW + IW;
	localparam int VOW = meat_pkg::VERT_W;
	localparam int FOW = meat_pkg::FACE_W;
	localparam int COW = meat_pkg::COUNT_W;

	meat_pkg::state_t  state_q, state_d;
	meat_pkg::status_t err_q, res_status_q;

	logic [CW-1:0] entry_q, bnd_q;
	logic [FB:0]   face_cnt_q;
	logic [KW-1:0] cursor_q;
	logic          started_q;

	logic [VB-1:0] va_q, vb_q, vc_q;
	logic [FB-1:0] face_q;
	logic [1:0]    edge_sel_q;
	logic [KW-1:0] key_q;
	logic          fw_q;
	logic [AW-1:0] cmp_idx_q;
	logic          found_q;
	logic [WW-1:0] best_q;
	logic          res_edge_q, res_nomore_q;

	logic                          out_valid_q;
	logic [meat_pkg::STATUS_W-1:0] out_status_q;
	logic                          out_edge_q, out_two_q, out_opp_q, out_nomore_q;
	logic [VOW-1:0]                out_lo_q, out_hi_q;
	logic [FOW-1:0]                out_f0_q, out_f1_q;
	logic [COW-1:0]                out_edges_q, out_bnd_q;

	// Table port.
	logic          ram_we;
	logic [AW-1:0] ram_wr_addr, ram_rd_addr;
	logic [WW-1:0] ram_wr_data, rd_word;

	logic          accept_c, out_free_c;
	logic [CW-1:0] idx_next_c;
	logic          more_c;
	logic [KW-1:0] rd_key;
	logic          rd_two;
	logic          hit_c, elig_c, better_c;
	logic [VB-1:0] u_c, v_c;
	logic          fw_c;
	logic [KW-1:0] key_c;
	logic          pair_c, fail_nm_c, fail_full_c, insert_c, next_edge_c;
	meat_pkg::op_t op_c;

	assign op_c       = meat_pkg::op_t'(op);
	assign accept_c   = in_valid && (state_q == meat_pkg::S_IDLE);
	assign in_stall   = (state_q != meat_pkg::S_IDLE);
	assign out_free_c = !out_valid_q || !out_stall;

	assign idx_next_c = CW'(cmp_idx_q) + CW'(1);
	assign more_c     = idx_next_c < entry_q;
	assign rd_key     = rd_word[IW +: KW];
	assign rd_two     = rd_word[2];
	assign hit_c      = (entry_q != '0) && (rd_key == key_q);
	assign elig_c     = !started_q || (rd_key > cursor_q);
	assign better_c   = !found_q || (rd_key < best_q[IW +: KW]);

	// Directed edge of the current triangle and its (low, high) key.
	always_comb begin
		unique case (edge_sel_q)
			2'd0: begin
				u_c = va_q;
				v_c = vb_q;
			end
			2'd1: begin
				u_c = vb_q;
				v_c = vc_q;
			end
			default: begin
				u_c = vc_q;
				v_c = va_q;
			end
		endcase
		fw_c  = u_c < v_c;
		key_c = fw_c ? {u_c, v_c} : {v_c, u_c};
	end

	meat_ram #(
		.WIDTH(WW),
		.DEPTH(EDGE_SLOTS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= meat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_rd_addr = '0;
		ram_wr_addr = cmp_idx_q;
		ram_wr_data = {key_q, face_q, {FB{1'b0}}, 1'b0, fw_q, 1'b0};
		pair_c      = 1'b0;
		fail_nm_c   = 1'b0;
		fail_full_c = 1'b0;
		insert_c    = 1'b0;
		next_edge_c = 1'b0;
		unique case (state_q)
			meat_pkg::S_IDLE: begin
				if (accept_c) begin
					unique case (op_c)
						meat_pkg::OP_ADD: begin
							if (err_q == meat_pkg::ST_OK && !face_cnt_q[FB]) begin
								state_d = meat_pkg::S_ADD_START;
							end else begin
								state_d = meat_pkg::S_EMIT;
							end
						end
						meat_pkg::OP_READ: begin
							if (err_q == meat_pkg::ST_OK && face_cnt_q != '0
									&& entry_q != '0) begin
								state_d = meat_pkg::S_RD_SCAN;
							end else begin
								state_d = meat_pkg::S_EMIT;
							end
						end
						meat_pkg::OP_BEGIN, meat_pkg::OP_NONE: begin
							state_d = meat_pkg::S_EMIT;
						end
					endcase
				end
			end
			meat_pkg::S_ADD_START: begin
				state_d = meat_pkg::S_ADD_SCAN;
			end
			meat_pkg::S_ADD_SCAN: begin
				if (hit_c) begin
					if (rd_two) begin
						fail_nm_c = 1'b1;
						state_d   = meat_pkg::S_EMIT;
					end else begin
						pair_c      = 1'b1;
						next_edge_c = 1'b1;
						ram_we      = 1'b1;
						ram_wr_data = {rd_word[WW-1:3], 1'b1, rd_word[1], fw_q};
						ram_wr_data[3 +: FB] = face_q;
					end
				end else if (more_c) begin
					ram_rd_addr = AW'(idx_next_c);
				end else if (entry_q >= CW'(EDGE_SLOTS)) begin
					fail_full_c = 1'b1;
					state_d     = meat_pkg::S_EMIT;
				end else begin
					insert_c    = 1'b1;
					next_edge_c = 1'b1;
					ram_we      = 1'b1;
					ram_wr_addr = entry_q[AW-1:0];
				end
				if (next_edge_c) begin
					state_d = (edge_sel_q == 2'd2) ? meat_pkg::S_EMIT : meat_pkg::S_ADD_START;
				end
			end
			meat_pkg::S_RD_SCAN: begin
				if (more_c) begin
					ram_rd_addr = AW'(idx_next_c);
				end else begin
					state_d = meat_pkg::S_RD_DONE;
				end
			end
			meat_pkg::S_RD_DONE: begin
				state_d = meat_pkg::S_EMIT;
			end
			meat_pkg::S_EMIT: begin
				if (out_free_c) begin
					state_d = meat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = meat_pkg::S_IDLE;
			end
		endcase
	end

	// Mesh state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q     <= '0;
			bnd_q       <= '0;
			face_cnt_q  <= '0;
			err_q       <= meat_pkg::ST_OK;
			cursor_q    <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_c) begin
				if (op_c == meat_pkg::OP_BEGIN) begin
					entry_q    <= '0;
					bnd_q      <= '0;
					face_cnt_q <= '0;
					err_q      <= meat_pkg::ST_OK;
					cursor_q   <= '0;
					started_q  <= 1'b0;
				end else if (op_c == meat_pkg::OP_ADD && err_q == meat_pkg::ST_OK) begin
					if (face_cnt_q[FB]) begin
						err_q   <= meat_pkg::ST_OVERFLOW;
						entry_q <= '0;
						bnd_q   <= '0;
					end else begin
						face_cnt_q <= face_cnt_q + 1'b1;
					end
				end
			end
			if (fail_nm_c || fail_full_c) begin
				err_q   <= fail_nm_c ? meat_pkg::ST_NON_MANIFOLD : meat_pkg::ST_OVERFLOW;
				entry_q <= '0;
				bnd_q   <= '0;
			end
			if (pair_c) begin
				bnd_q <= bnd_q - 1'b1;
			end
			if (insert_c) begin
				entry_q <= entry_q + 1'b1;
				bnd_q   <= bnd_q + 1'b1;
			end
			if (state_q == meat_pkg::S_RD_DONE && found_q) begin
				cursor_q  <= best_q[IW +: KW];
				started_q <= 1'b1;
			end
			if (state_q == meat_pkg::S_EMIT && out_free_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-item working registers and the output payload.
	always_ff @(posedge clk) begin
		if (accept_c) begin
			va_q         <= vert_a[VB-1:0];
			vb_q         <= vert_b[VB-1:0];
			vc_q         <= vert_c[VB-1:0];
			face_q       <= face_cnt_q[FB-1:0];
			edge_sel_q   <= 2'd0;
			cmp_idx_q    <= '0;
			found_q      <= 1'b0;
			res_edge_q   <= 1'b0;
			// With no stored edges the read ends at once.
			res_nomore_q <= (op_c == meat_pkg::OP_READ) && (err_q == meat_pkg::ST_OK)
					&& (face_cnt_q != '0) && (entry_q == '0);
			unique case (op_c)
				meat_pkg::OP_BEGIN: begin
					res_status_q <= meat_pkg::ST_OK;
				end
				meat_pkg::OP_ADD: begin
					if (err_q != meat_pkg::ST_OK) begin
						res_status_q <= err_q;
					end else if (face_cnt_q[FB]) begin
						res_status_q <= meat_pkg::ST_OVERFLOW;
					end else begin
						res_status_q <= meat_pkg::ST_OK;
					end
				end
				meat_pkg::OP_READ: begin
					if (err_q != meat_pkg::ST_OK) begin
						res_status_q <= err_q;
					end else if (face_cnt_q == '0) begin
						res_status_q <= meat_pkg::ST_EMPTY;
					end else begin
						res_status_q <= meat_pkg::ST_OK;
					end
				end
				meat_pkg::OP_NONE: begin
					res_status_q <= err_q;
				end
			endcase
		end
		if (state_q == meat_pkg::S_ADD_START) begin
			key_q     <= key_c;
			fw_q      <= fw_c;
			cmp_idx_q <= '0;
		end
		if (state_q == meat_pkg::S_ADD_SCAN) begin
			if (!hit_c && more_c) begin
				cmp_idx_q <= AW'(idx_next_c);
			end
			if (next_edge_c) begin
				edge_sel_q <= edge_sel_q + 2'd1;
			end
			if (fail_nm_c) begin
				res_status_q <= meat_pkg::ST_NON_MANIFOLD;
			end
			if (fail_full_c) begin
				res_status_q <= meat_pkg::ST_OVERFLOW;
			end
		end
		if (state_q == meat_pkg::S_RD_SCAN) begin
			if (more_c) begin
				cmp_idx_q <= AW'(idx_next_c);
			end
			// Keep the smallest key above the last one returned.
			if (elig_c && better_c) begin
				best_q  <= rd_word;
				found_q <= 1'b1;
			end
		end
		if (state_q == meat_pkg::S_RD_DONE) begin
			res_edge_q   <= found_q;
			res_nomore_q <= !found_q;
		end
		if (state_q == meat_pkg::S_EMIT && out_free_c) begin
			out_status_q <= res_status_q;
			out_edge_q   <= res_edge_q;
			out_nomore_q <= res_nomore_q;
			out_edges_q  <= COW'(entry_q);
			out_bnd_q    <= COW'(bnd_q);
			if (res_edge_q) begin
				out_lo_q  <= VOW'(best_q[IW + VB +: VB]);
				out_hi_q  <= VOW'(best_q[IW +: VB]);
				out_f0_q  <= FOW'(best_q[FB + 3 +: FB]);
				out_f1_q  <= best_q[2] ? FOW'(best_q[3 +: FB]) : '0;
				out_two_q <= best_q[2];
				out_opp_q <= best_q[2] && (best_q[1] != best_q[0]);
			end else begin
				out_lo_q  <= '0;
				out_hi_q  <= '0;
				out_f0_q  <= '0;
				out_f1_q  <= '0;
				out_two_q <= 1'b0;
				out_opp_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign edge_valid     = out_edge_q;
	assign vert_low       = out_lo_q;
	assign vert_high      = out_hi_q;
	assign face_one       = out_f0_q;
	assign face_two       = out_f1_q;
	assign has_second     = out_two_q;
	assign opposite       = out_opp_q;
	assign edges_total    = out_edges_q;
	assign boundary_total = out_bnd_q;
	assign no_more        = out_nomore_q;

`ifndef SYNTHESIS
	a_bnd_le_entries: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_q <= entry_q)
		else $error("boundary count exceeds edge count");

	a_entries_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		entry_q <= CW'(EDGE_SLOTS))
		else $error("edge count exceeds table size");

	a_err_table_empty: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != meat_pkg::ST_OK |-> entry_q == '0 && bnd_q == '0)
		else $error("table holds edges while an error is latched");

	a_edge_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_valid |-> status == meat_pkg::ST_OK && !no_more)
		else $error("edge returned with bad status or end flag");
`endif

endmodule

### sim/tb_mesh_edge_adjacency_table.sv
`timescale 1ns / 1ps

module tb_mesh_edge_adjacency_table;

	localparam int SLOTS          = meat_pkg::EDGE_SLOTS_DEF;
	localparam int FACE_LIMIT     = 1 << meat_pkg::FACE_BITS_DEF;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int VW             = meat_pkg::VERT_W;
	localparam int FW             = meat_pkg::FACE_W;
	localparam int CNW            = meat_pkg::COUNT_W;

	typedef struct packed {
		meat_pkg::op_t code;
		logic [VW-1:0] va;
		logic [VW-1:0] vb;
		logic [VW-1:0] vc;
	} mesh_cmd_t;

	typedef struct packed {
		meat_pkg::status_t status;
		logic              edge_valid;
		logic [VW-1:0]     vert_low;
		logic [VW-1:0]     vert_high;
		logic [FW-1:0]     face_one;
		logic [FW-1:0]     face_two;
		logic              has_second;
		logic              opposite;
		logic [CNW-1:0]    edges_total;
		logic [CNW-1:0]    boundary_total;
		logic              no_more;
	} edge_report_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [meat_pkg::OP_W-1:0]     op = meat_pkg::OP_NONE;
	logic [VW-1:0]                 vert_a = '0;
	logic [VW-1:0]                 vert_b = '0;
	logic [VW-1:0]                 vert_c = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [meat_pkg::STATUS_W-1:0] status;
	logic                          edge_valid;
	logic [VW-1:0]                 vert_low;
	logic [VW-1:0]                 vert_high;
	logic [FW-1:0]                 face_one;
	logic [FW-1:0]                 face_two;
	logic                          has_second;
	logic                          opposite;
	logic [CNW-1:0]                edges_total;
	logic [CNW-1:0]                boundary_total;
	logic                          no_more;

	mesh_cmd_t    pending_cmds[$];
	edge_report_t pending_reports[$];
	int           queued_items = 0;
	int           failures = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           hold_requests = 0;
	int           holds_done = 0;
	int           hold_left = 0;
	int           quiet_cycles = 0;

	// Shadow copy of the edge table.
	logic [63:0]       tbl_key    [SLOTS];
	int unsigned       tbl_first  [SLOTS];
	int unsigned       tbl_second [SLOTS];
	bit                tbl_shared [SLOTS];
	bit                tbl_fwd0   [SLOTS];
	bit                tbl_fwd1   [SLOTS];
	int unsigned       edge_cnt = 0;
	int unsigned       open_cnt = 0;
	int unsigned       face_cnt = 0;
	meat_pkg::status_t latched_err = meat_pkg::ST_OK;
	logic [63:0]       cursor_key = '0;
	bit                cursor_set = 1'b0;

	mesh_edge_adjacency_table u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.vert_a         (vert_a),
		.vert_b         (vert_b),
		.vert_c         (vert_c),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.edge_valid     (edge_valid),
		.vert_low       (vert_low),
		.vert_high      (vert_high),
		.face_one       (face_one),
		.face_two       (face_two),
		.has_second     (has_second),
		.opposite       (opposite),
		.edges_total    (edges_total),
		.boundary_total (boundary_total),
		.no_more        (no_more)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void latch_error(meat_pkg::status_t code);
		latched_err = code;
		edge_cnt = 0;
		open_cnt = 0;
	endfunction

	// Adds one directed edge of a face; returns 0 when it latches an error.
	function automatic bit record_edge(logic [VW-1:0] u, logic [VW-1:0] v,
			int unsigned face);
		bit fwd;
		logic [63:0] key;
		int i;
		fwd = u < v;
		key = fwd ? {u, v} : {v, u};
		for (i = 0; i < edge_cnt; i++) begin
			if (tbl_key[i] == key) begin
				if (tbl_shared[i]) begin
					latch_error(meat_pkg::ST_NON_MANIFOLD);
					return 1'b0;
				end
				tbl_shared[i] = 1'b1;
				tbl_second[i] = face;
				tbl_fwd1[i] = fwd;
				open_cnt--;
				return 1'b1;
			end
		end
		if (edge_cnt >= SLOTS) begin
			latch_error(meat_pkg::ST_OVERFLOW);
			return 1'b0;
		end
		tbl_key[edge_cnt] = key;
		tbl_first[edge_cnt] = face;
		tbl_second[edge_cnt] = 0;
		tbl_shared[edge_cnt] = 1'b0;
		tbl_fwd0[edge_cnt] = fwd;
		tbl_fwd1[edge_cnt] = 1'b0;
		edge_cnt++;
		open_cnt++;
		return 1'b1;
	endfunction

	function automatic edge_report_t update_adjacency(meat_pkg::op_t code, logic [VW-1:0] a,
			logic [VW-1:0] b, logic [VW-1:0] c);
		edge_report_t r;
		int found;
		int i;
		int unsigned face;
		r = '0;
		r.status = latched_err;
		found = -1;
		case (code)
			meat_pkg::OP_BEGIN: begin
				edge_cnt = 0;
				open_cnt = 0;
				face_cnt = 0;
				latched_err = meat_pkg::ST_OK;
				cursor_key = '0;
				cursor_set = 1'b0;
				r.status = meat_pkg::ST_OK;
			end
			meat_pkg::OP_ADD: begin
				if (latched_err == meat_pkg::ST_OK) begin
					if (face_cnt >= FACE_LIMIT) begin
						latch_error(meat_pkg::ST_OVERFLOW);
					end else begin
						face = face_cnt;
						face_cnt++;
						if (record_edge(a, b, face)) begin
							if (record_edge(b, c, face)) begin
								void'(record_edge(c, a, face));
							end
						end
					end
				end
				r.status = latched_err;
			end
			meat_pkg::OP_READ: begin
				if (latched_err != meat_pkg::ST_OK) begin
					r.status = latched_err;
				end else if (face_cnt == 0) begin
					r.status = meat_pkg::ST_EMPTY;
				end else begin
					r.status = meat_pkg::ST_OK;
					for (i = 0; i < edge_cnt; i++) begin
						if (cursor_set && tbl_key[i] <= cursor_key) continue;
						if (found < 0 || tbl_key[i] < tbl_key[found]) found = i;
					end
					if (found < 0) begin
						r.no_more = 1'b1;
					end else begin
						cursor_key = tbl_key[found];
						cursor_set = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (found >= 0) begin
			r.edge_valid = 1'b1;
			r.vert_low = tbl_key[found][63:32];
			r.vert_high = tbl_key[found][31:0];
			r.face_one = FW'(tbl_first[found]);
			if (tbl_shared[found]) begin
				r.face_two = FW'(tbl_second[found]);
				r.has_second = 1'b1;
				r.opposite = tbl_fwd0[found] != tbl_fwd1[found];
			end
		end
		r.edges_total = CNW'(edge_cnt);
		r.boundary_total = CNW'(open_cnt);
		return r;
	endfunction

	function automatic void queue_cmd(meat_pkg::op_t code, logic [VW-1:0] a,
			logic [VW-1:0] b, logic [VW-1:0] c);
		mesh_cmd_t cmd;
		cmd = '{code, a, b, c};
		pending_cmds = {pending_cmds, cmd};
		queued_items++;
	endfunction

	function automatic logic [VW-1:0] pick_vertex();
		case ($urandom_range(4))
			0: return VW'($urandom_range(15));
			1: return 32'hFFFF_FFFF - VW'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// A triangle strip, mostly with consistent winding, sprinkled with reads, unknown ops and
	// stray triangles, then read out by a run of reads.
	task automatic queue_mesh();
		logic [VW-1:0] pool [12];
		logic [VW-1:0] x, y, z;
		int n_verts;
		int n_reads;
		int i;
		n_verts = $urandom_range(12, 3);
		foreach (pool[k]) pool[k] = pick_vertex();
		queue_cmd(meat_pkg::OP_BEGIN, $urandom, $urandom, $urandom);
		if ($urandom_range(3) == 0) queue_cmd(meat_pkg::OP_READ, $urandom, $urandom, $urandom);
		for (i = 0; i + 2 < n_verts; i++) begin
			x = (i % 2 == 0) ? pool[i] : pool[i + 1];
			y = (i % 2 == 0) ? pool[i + 1] : pool[i];
			z = pool[i + 2];
			if ($urandom_range(5) == 0) {x, y} = {y, x};
			queue_cmd(meat_pkg::OP_ADD, x, y, z);
			case ($urandom_range(11))
				0: queue_cmd(meat_pkg::OP_READ, $urandom, $urandom, $urandom);
				1: queue_cmd(meat_pkg::OP_NONE, $urandom, $urandom, $urandom);
				2: queue_cmd(meat_pkg::OP_ADD, pool[$urandom_range(n_verts - 1)],
					pool[$urandom_range(n_verts - 1)], pool[$urandom_range(n_verts - 1)]);
				default: ;
			endcase
		end
		// Two more faces on the first triangle's edges give a non-manifold edge.
		if ($urandom_range(7) == 0) begin
			repeat (2) queue_cmd(meat_pkg::OP_ADD, pool[0], pool[1], pool[2]);
		end
		n_reads = 2 * n_verts + $urandom_range(2);
		for (i = 0; i < n_reads; i++) begin
			queue_cmd(meat_pkg::OP_READ, $urandom, $urandom, $urandom);
			if ($urandom_range(15) == 0) begin
				queue_cmd(meat_pkg::OP_ADD, pick_vertex(), pick_vertex(), pick_vertex());
			end
		end
	endtask

	task automatic queue_noise();
		int i;
		for (i = 0; i < 8; i++) begin
			queue_cmd(meat_pkg::op_t'($urandom_range(3)), pick_vertex(), pick_vertex(),
				pick_vertex());
		end
	endtask

	task automatic drain();
		do begin
			@(negedge clk);
		end while (pending_cmds.size() != 0 || in_valid || pending_reports.size() != 0);
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, int n_items);
		int target;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		target = queued_items + n_items;
		while (queued_items < target) begin
			if ($urandom_range(4) == 0) begin
				queue_noise();
			end else begin
				queue_mesh();
			end
		end
		drain();
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		mesh_cmd_t next_cmd;
		edge_report_t next_rep;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				next_rep = update_adjacency(meat_pkg::op_t'(op), vert_a, vert_b, vert_c);
				pending_reports = {pending_reports, next_rep};
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					op <= next_cmd.code;
					vert_a <= next_cmd.va;
					vert_b <= next_cmd.vb;
					vert_c <= next_cmd.vc;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// A requested hold-off keeps the result side stalled so that the block backs up onto
	// its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin : check_proc
		edge_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("result transfer with no expectation waiting");
				failures++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", want.status, status);
				check_field("edge_valid", want.edge_valid, edge_valid);
				check_field("vert_low", want.vert_low, vert_low);
				check_field("vert_high", want.vert_high, vert_high);
				check_field("face_one", want.face_one, face_one);
				check_field("face_two", want.face_two, face_two);
				check_field("has_second", want.has_second, has_second);
				check_field("opposite", want.opposite, opposite);
				check_field("edges_total", want.edges_total, edges_total);
				check_field("boundary_total", want.boundary_total, boundary_total);
				check_field("no_more", want.no_more, no_more);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[mesh_edge_adjacency_table] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : main_proc
		int i;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty read, extremes, a shared edge walked both ways, a degenerate
		// face, an add below the read position, and a non-manifold error.
		queue_cmd(meat_pkg::OP_READ, 32'h0, 32'h0, 32'h0);
		queue_cmd(meat_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(meat_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'h1);
		queue_cmd(meat_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h2);
		queue_cmd(meat_pkg::OP_ADD, 32'h7, 32'h7, 32'h9);
		repeat (5) queue_cmd(meat_pkg::OP_READ, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0);
		queue_cmd(meat_pkg::OP_ADD, 32'h0, 32'h5, 32'h6);
		repeat (4) queue_cmd(meat_pkg::OP_READ, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
		queue_cmd(meat_pkg::OP_NONE, 32'h0, 32'h0, 32'h0);
		queue_cmd(meat_pkg::OP_ADD, 32'h4, 32'h0, 32'hFFFF_FFFF);
		queue_cmd(meat_pkg::OP_ADD, 32'h10, 32'h11, 32'h12);
		queue_cmd(meat_pkg::OP_READ, 32'h0, 32'h0, 32'h0);
		queue_cmd(meat_pkg::OP_NONE, 32'h0, 32'h0, 32'h0);
		queue_cmd(meat_pkg::OP_BEGIN, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		queue_cmd(meat_pkg::OP_READ, 32'h0, 32'h0, 32'h0);
		queue_cmd(meat_pkg::OP_ADD, 32'h5, 32'h5, 32'h5);
		queue_cmd(meat_pkg::OP_BEGIN, 32'h0, 32'h0, 32'h0);
		drain();

		run_random_phase(0, 0, 28);
		run_random_phase(82, 0, 28);
		run_random_phase(0, 82, 28);
		run_random_phase(6, 6, 28);

		// Back-pressure: the result side holds off while cheap items keep coming.
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests++;
		queue_cmd(meat_pkg::OP_BEGIN, $urandom, $urandom, $urandom);
		for (i = 0; i < 4; i++) begin
			queue_cmd(meat_pkg::OP_ADD, pick_vertex(), pick_vertex(), pick_vertex());
		end
		for (i = 0; i < 16; i++) queue_cmd(meat_pkg::OP_READ, $urandom, $urandom, $urandom);
		drain();

		repeat (100) @(negedge clk);
		if (failures == 0 && pending_reports.size() == 0) begin
			$display("[mesh_edge_adjacency_table] OK");
		end else begin
			$display("[mesh_edge_adjacency_table] ERROR");
		end
		$finish;
	end

endmodule
